FILE: hw/rtl/s57trg_pkg.sv
// ----------------------------------------------------------------------------
// s57trg_pkg
// Shared types, panel constants and the 5x7 font table of the scaled text
// rectangle generator.
// ----------------------------------------------------------------------------
package s57trg_pkg;

  localparam int H_RES   = 240;
  localparam int V_RES   = 240;
  localparam int COORD_W = 12;
  localparam int CURSOR_MAX = 1023;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [GLYPH_BITS-1:0]     glyph_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Rows top first, each row left column in its MSB; unknown codes are blank.
  function automatic glyph_t glyph_bits(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      8'h49: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h58: g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11};
      8'h59: g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      8'h61: g = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
      8'h64: g = {5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h11, 5'h0F};
      8'h67: g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
      8'h69: g = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h6D: g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15};
      8'h6E: g = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
      8'h6F: g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h72: g = {5'h00, 5'h00, 5'h16, 5'h18, 5'h10, 5'h10, 5'h10};
      8'h74: g = {5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h09, 5'h06};
      8'h75: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D};
      8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      8'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
      8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      8'h25: g = {5'h19, 5'h1A, 5'h02, 5'h04, 5'h08, 5'h0B, 5'h13};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: hw/rtl/scaled_5x7_text_rectangle_generator_top.sv
// ----------------------------------------------------------------------------
// scaled_5x7_text_rectangle_generator_top
// Turns one character word into up to 35 clipped fill rectangle words, one
// glyph cell per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
// A new character is accepted only in idle, after the cell steps and the flush
//   of the one before; output stalls hold the cell walk.
// The first rectangle word waits in the pending register until the next
//   visible cell or the flush moves it to the output register; the cell
//   sequencer walks the columns of each row, row by row, with one adder pair.
// Reset: rst clears the sequencer, the output valid and the cursor to 0.
// ----------------------------------------------------------------------------
module scaled_5x7_text_rectangle_generator_top
  import s57trg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               begin_text,
  input  logic signed [10:0] start_x,
  input  logic signed [10:0] top_y,
  input  logic [7:0]         char_code,
  input  logic [15:0]        fg_color,
  input  logic [15:0]        bg_color,
  input  logic [3:0]         scale,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         rect_x1,
  output logic [7:0]         rect_y1,
  output logic [7:0]         rect_x2,
  output logic [7:0]         rect_y2,
  output logic [15:0]        fill_color,
  output logic               last_rect
);

  localparam coord_t H_MAX = COORD_W'(H_RES);
  localparam coord_t V_MAX = COORD_W'(V_RES);
  localparam coord_t C_MAX = COORD_W'(CURSOR_MAX);

  state_t      state;
  coord_t      cursor_x;
  coord_t      x_base;
  coord_t      xc;
  coord_t      yc;
  logic [2:0]  col;
  logic [2:0]  row;
  glyph_t      glyph;
  logic [15:0] fg;
  logic [15:0] bg;
  logic [3:0]  s;

  logic        pend_valid;
  logic [7:0]  pend_x1;
  logic [7:0]  pend_y1;
  logic [7:0]  pend_x2;
  logic [7:0]  pend_y2;
  logic [15:0] pend_color;

  coord_t      x_sel;
  coord_t      cursor_sum;
  coord_t      cursor_next;
  coord_t      s_ext;
  coord_t      xe;
  coord_t      ye;
  coord_t      x1c;
  coord_t      y1c;
  coord_t      x2c;
  coord_t      y2c;
  logic        cell_ok;
  logic        out_free;
  logic        in_acc;
  logic        stall;
  logic        last_cell;
  logic        load_out;
  logic        load_last;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign x_sel       = begin_text ? coord_t'(start_x) : cursor_x;
  assign cursor_sum  = x_sel + coord_t'({scale, 2'b00}) + coord_t'({scale, 1'b0});
  assign cursor_next = (cursor_sum > C_MAX) ? C_MAX : cursor_sum;

  assign s_ext   = coord_t'({1'b0, s});
  assign xe      = xc + s_ext;
  assign ye      = yc + s_ext;
  assign x1c     = (xc < 0) ? '0 : xc;
  assign y1c     = (yc < 0) ? '0 : yc;
  assign x2c     = (xe > H_MAX) ? H_MAX : xe;
  assign y2c     = (ye > V_MAX) ? V_MAX : ye;
  assign cell_ok = (x2c > x1c) && (y2c > y1c);

  assign last_cell = (row == 3'(GLYPH_ROWS - 1)) && (col == 3'(GLYPH_COLS - 1));
  assign stall     = (state == ST_RUN) && cell_ok && pend_valid && !out_free;
  assign load_out  = (state == ST_RUN) && cell_ok && pend_valid && out_free;
  assign load_last = (state == ST_FLUSH) && pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_x   <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cursor_x <= cursor_next;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!stall) begin
            if (cell_ok) begin
              pend_valid <= 1'b1;
            end
            if (last_cell) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer datapath: latch the word, then walk the cells.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_base <= x_sel;
      xc     <= x_sel;
      yc     <= coord_t'(top_y);
      col    <= '0;
      row    <= '0;
      glyph  <= glyph_bits(char_code);
      fg     <= fg_color;
      bg     <= bg_color;
      s      <= scale;
    end else if (state == ST_RUN && !stall) begin
      glyph <= {glyph[GLYPH_BITS-2:0], 1'b0};
      if (col == 3'(GLYPH_COLS - 1)) begin
        col <= '0;
        row <= row + 3'd1;
        xc  <= x_base;
        yc  <= ye;
      end else begin
        col <= col + 3'd1;
        xc  <= xe;
      end
      if (cell_ok) begin
        pend_x1    <= x1c[7:0];
        pend_y1    <= y1c[7:0];
        pend_x2    <= x2c[7:0];
        pend_y2    <= y2c[7:0];
        pend_color <= glyph[GLYPH_BITS-1] ? fg : bg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out || load_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out || load_last) begin
      rect_x1    <= pend_x1;
      rect_y1    <= pend_y1;
      rect_x2    <= pend_x2;
      rect_y2    <= pend_y2;
      fill_color <= pend_color;
      last_rect  <= load_last;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held rectangle left over in idle");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_RUN) && (col == 3'd0) && (row == 3'd0))
    else $error("accepted word did not start the cell walk");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (col < 3'(GLYPH_COLS)) && (row < 3'(GLYPH_ROWS)))
    else $error("cell counters out of range");

  a_cursor_sat: assert property (@(posedge clk) disable iff (rst)
    cursor_x <= C_MAX)
    else $error("cursor above saturation limit");

  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    load_last |=> (state == ST_IDLE) && out_valid && last_rect)
    else $error("final rectangle not marked last");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scaled 5x7 text rectangle generator. A driver
// plays character words out in random bursts and a monitor takes rectangle
// words under a shifting stall pattern. Every accepted character is rendered
// by an in-bench glyph painter into the list of rectangles it must produce,
// and each rectangle word that arrives is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import s57trg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_CHARS = 200;
  localparam int SAT_X = 1023;
  localparam int NUM_GLYPHS = 42;
  localparam logic [8*NUM_GLYPHS-1:0] GLYPH_CODES =
    "ABCDGIMNOPRSTUXYZadgimnortu0123456789:.-% ";

  typedef struct packed {
    logic        begin_text;
    logic [10:0] start_x;
    logic [10:0] top_y;
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [3:0]  scale;
    logic        drain;
  } char_word_t;

  typedef struct packed {
    logic [7:0]  x1;
    logic [7:0]  y1;
    logic [7:0]  x2;
    logic [7:0]  y2;
    logic [15:0] color;
    logic        last;
  } rect_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        begin_text = 1'b0;
  logic [10:0] start_x = '0;
  logic [10:0] top_y = '0;
  logic [7:0]  char_code = '0;
  logic [15:0] fg_color = '0;
  logic [15:0] bg_color = '0;
  logic [3:0]  scale = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  rect_x1;
  logic [7:0]  rect_y1;
  logic [7:0]  rect_x2;
  logic [7:0]  rect_y2;
  logic [15:0] fill_color;
  logic        last_rect;

  char_word_t pending_chars[$];
  rect_word_t expected_rects[$];

  int text_cursor = 0;
  int errors = 0;
  int chars_sent = 0;
  int blank_chars = 0;
  int rects_seen = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int ready_hold = 0;

  scaled_5x7_text_rectangle_generator_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .begin_text(begin_text),
    .start_x(start_x),
    .top_y(top_y),
    .char_code(char_code),
    .fg_color(fg_color),
    .bg_color(bg_color),
    .scale(scale),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rect_x1(rect_x1),
    .rect_y1(rect_y1),
    .rect_x2(rect_x2),
    .rect_y2(rect_y2),
    .fill_color(fill_color),
    .last_rect(last_rect)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Seven rows of five cells, top row in the high byte, left cell in bit 4.
  function automatic logic [55:0] glyph_rows(input logic [7:0] code);
    logic [55:0] r;
    case (code)
      "A": r = 56'h0E_11_11_1F_11_11_11;
      "B": r = 56'h1E_11_11_1E_11_11_1E;
      "C": r = 56'h0E_11_10_10_10_11_0E;
      "D": r = 56'h1E_11_11_11_11_11_1E;
      "G": r = 56'h0E_11_10_17_11_11_0E;
      "I": r = 56'h1F_04_04_04_04_04_1F;
      "M": r = 56'h11_1B_15_15_11_11_11;
      "N": r = 56'h11_19_15_13_11_11_11;
      "O": r = 56'h0E_11_11_11_11_11_0E;
      "P": r = 56'h1E_11_11_1E_10_10_10;
      "R": r = 56'h1E_11_11_1E_14_12_11;
      "S": r = 56'h0F_10_10_0E_01_01_1E;
      "T": r = 56'h1F_04_04_04_04_04_04;
      "U": r = 56'h11_11_11_11_11_11_0E;
      "X": r = 56'h11_0A_04_04_04_0A_11;
      "Y": r = 56'h11_0A_04_04_04_04_04;
      "Z": r = 56'h1F_01_02_04_08_10_1F;
      "a": r = 56'h00_00_0E_01_0F_11_0F;
      "d": r = 56'h01_01_0F_11_11_11_0F;
      "g": r = 56'h00_0F_11_11_0F_01_0E;
      "i": r = 56'h04_00_0C_04_04_04_0E;
      "m": r = 56'h00_00_1A_15_15_15_15;
      "n": r = 56'h00_00_1E_11_11_11_11;
      "o": r = 56'h00_00_0E_11_11_11_0E;
      "r": r = 56'h00_00_16_18_10_10_10;
      "t": r = 56'h08_08_1E_08_08_09_06;
      "u": r = 56'h00_00_11_11_11_13_0D;
      "0": r = 56'h0E_11_13_15_19_11_0E;
      "1": r = 56'h04_0C_04_04_04_04_0E;
      "2": r = 56'h0E_11_01_02_04_08_1F;
      "3": r = 56'h1E_01_01_0E_01_01_1E;
      "4": r = 56'h02_06_0A_12_1F_02_02;
      "5": r = 56'h1F_10_10_1E_01_01_1E;
      "6": r = 56'h0E_10_10_1E_11_11_0E;
      "7": r = 56'h1F_01_02_04_08_08_08;
      "8": r = 56'h0E_11_11_0E_11_11_0E;
      "9": r = 56'h0E_11_11_0F_01_01_0E;
      ":": r = 56'h00_04_04_00_04_04_00;
      ".": r = 56'h00_00_00_00_00_06_06;
      "-": r = 56'h00_00_00_1F_00_00_00;
      "%": r = 56'h19_1A_02_04_08_0B_13;
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic render_char(input char_word_t w);
    int x0, y0, s, x1, y1, x2, y2, n;
    logic [55:0] rows;
    logic [7:0] bits;
    rect_word_t r;
    rect_word_t prev;
    x0 = w.begin_text ? int'($signed(w.start_x)) : text_cursor;
    y0 = int'($signed(w.top_y));
    s = int'(w.scale);
    rows = glyph_rows(w.char_code);
    n = 0;
    prev = '0;
    for (int row = 0; row < 7; row++) begin
      bits = rows[55 - 8*row -: 8];
      for (int col = 0; col < 5; col++) begin
        x1 = x0 + col * s;
        x2 = x0 + (col + 1) * s;
        y1 = y0 + row * s;
        y2 = y0 + (row + 1) * s;
        if (x1 < 0) x1 = 0;
        if (y1 < 0) y1 = 0;
        if (x2 > H_RES) x2 = H_RES;
        if (y2 > V_RES) y2 = V_RES;
        if (x2 > x1 && y2 > y1) begin
          r.x1 = x1[7:0];
          r.y1 = y1[7:0];
          r.x2 = x2[7:0];
          r.y2 = y2[7:0];
          r.color = bits[4 - col] ? w.fg_color : w.bg_color;
          r.last = 1'b0;
          if (n > 0) expected_rects.push_back(prev);
          prev = r;
          n++;
        end
      end
    end
    if (n > 0) begin
      prev.last = 1'b1;
      expected_rects.push_back(prev);
    end else begin
      blank_chars++;
    end
    x0 = x0 + 6 * s;
    text_cursor = (x0 > SAT_X) ? SAT_X : x0;
  endtask

  task automatic add_char(input logic b, input logic [10:0] sx, input logic [10:0] ty,
                          input logic [7:0] code, input logic [15:0] fg,
                          input logic [15:0] bg, input logic [3:0] sc,
                          input logic drain);
    char_word_t w;
    w.begin_text = b;
    w.start_x = sx;
    w.top_y = ty;
    w.char_code = code;
    w.fg_color = fg;
    w.bg_color = bg;
    w.scale = sc;
    w.drain = drain;
    pending_chars.push_back(w);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : sender
    char_word_t w;
    char_word_t seen;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        seen = '0;
        seen.begin_text = begin_text;
        seen.start_x = start_x;
        seen.top_y = top_y;
        seen.char_code = char_code;
        seen.fg_color = fg_color;
        seen.bg_color = bg_color;
        seen.scale = scale;
        render_char(seen);
        chars_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() > 0 &&
                     !(pending_chars[0].drain && expected_rects.size() > 0)) begin
          w = pending_chars.pop_front();
          begin_text <= w.begin_text;
          start_x <= w.start_x;
          top_y <= w.top_y;
          char_code <= w.char_code;
          fg_color <= w.fg_color;
          bg_color <= w.bg_color;
          scale <= w.scale;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    rect_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rects_seen++;
        if (expected_rects.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected rectangle word, expected none, actual %0d,%0d..%0d,%0d",
                   $time, rect_x1, rect_y1, rect_x2, rect_y2);
        end else begin
          want = expected_rects.pop_front();
          check_field("rect_x1", int'(want.x1), int'(rect_x1));
          check_field("rect_y1", int'(want.y1), int'(rect_y1));
          check_field("rect_x2", int'(want.x2), int'(rect_x2));
          check_field("rect_y2", int'(want.y2), int'(rect_y2));
          check_field("fill_color", int'(want.color), int'(fill_color));
          check_field("last_rect", int'(want.last), int'(last_rect));
        end
      end
      if (ready_hold == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_hold = $urandom_range(50, 400);
      end else begin
        ready_hold--;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cycles % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int len;
    logic [3:0] sc;
    logic [10:0] ty;
    logic [7:0] code;
    add_char(1'b1, 0, 0, "A", 16'hFFFF, 16'h0000, 1, 1'b0);
    add_char(1'b0, 0, 0, "B", 16'hFFFF, 16'h0000, 1, 1'b0);
    add_char(1'b0, 0, 0, "%", 16'h0000, 16'hFFFF, 2, 1'b0);
    add_char(1'b1, 0, 20, 8'hFF, 16'h1234, 16'hABCD, 3, 1'b0);
    add_char(1'b0, 0, 20, 8'h80, 16'h1234, 16'h5555, 3, 1'b0);
    add_char(1'b0, 0, 20, 8'h00, 16'h1234, 16'hAAAA, 2, 1'b0);
    add_char(1'b0, 0, 20, "Z", 16'hF800, 16'h07E0, 0, 1'b0);
    add_char(1'b0, 0, 20, "Y", 16'hF800, 16'h07E0, 1, 1'b0);
    add_char(1'b1, -20, -30, "M", 16'h001F, 16'hFFE0, 15, 1'b0);
    add_char(1'b1, 230, 230, "8", 16'h8001, 16'h7FFE, 15, 1'b0);
    add_char(1'b1, -1024, -1024, "O", 16'hFFFF, 16'h0000, 15, 1'b0);
    add_char(1'b1, 1023, 0, "X", 16'hFFFF, 16'h0000, 15, 1'b0);
    add_char(1'b0, 0, 0, "0", 16'hFFFF, 16'h0000, 1, 1'b0);
    add_char(1'b1, 239, 239, "I", 16'hC3C3, 16'h3C3C, 1, 1'b0);
    add_char(1'b1, 0, 100, " ", 16'hFFFF, 16'h0F0F, 4, 1'b1);
    add_char(1'b1, 200, 10, "g", 16'h0001, 16'hFFFE, 15, 1'b0);
    add_char(1'b1, -1, 0, "T", 16'hFFFF, 16'h0000, 1, 1'b0);
    add_char(1'b1, 0, 1023, "4", 16'hFFFF, 16'h0000, 15, 1'b0);
    add_char(1'b1, 1000, 5, "u", 16'h5A5A, 16'hA5A5, 7, 1'b0);

    n = 0;
    while (n < RANDOM_CHARS) begin
      if ($urandom_range(0, 99) < 12) begin
        add_char(1'($urandom_range(0, 1)), 11'($urandom), 11'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom), 4'($urandom), (n % 60 == 59));
        n++;
      end else begin
        len = $urandom_range(1, 8);
        sc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 5));
        ty = 11'($urandom_range(0, 260) - 20);
        for (int k = 0; k < len && n < RANDOM_CHARS; k++) begin
          code = ($urandom_range(0, 99) < 85) ?
                 GLYPH_CODES[8*$urandom_range(0, NUM_GLYPHS-1) +: 8] : 8'($urandom);
          add_char(k == 0, (k == 0) ? 11'($urandom_range(0, 260) - 20) : 11'($urandom),
                   ty, code, 16'($urandom), 16'($urandom), sc, (n % 60 == 59));
          n++;
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_chars.size() > 0 || in_valid) @(posedge clk);
    while (expected_rects.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d characters (%0d drew nothing) and checked %0d rectangles",
             chars_sent, blank_chars, rects_seen);
    $display("mismatches: %0d, cycles: %0d", errors, cycles);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
